>>> rtl/ids_pkg.sv
// Shared types and codes for the include directive scanner.
`timescale 1ns / 1ps
`default_nettype none

package ids_pkg;

    // Scanner phase codes.
    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_INLINE = 4'd1,
        PH_HASH   = 4'd2,
        PH_INCL   = 4'd3,
        PH_NAME   = 4'd4,
        PH_SLASH  = 4'd5,
        PH_ESCAPE = 4'd6,
        PH_BLOCK  = 4'd7,
        PH_BSTAR  = 4'd8,
        PH_LCOMM  = 4'd9
    } phase_t;

    // Event kinds carried by a result transaction.
    typedef enum logic [1:0] {
        EV_CHAR = 2'd0,
        EV_DONE = 2'd1,
        EV_DROP = 2'd2
    } event_kind_t;

    // One result transaction.
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  ch;
        logic        angle;
    } event_t;

    // One input transaction as held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       eof;
    } item_t;

endpackage : ids_pkg

`default_nettype wire

>>> rtl/include_directive_scanner.sv
// Top level of the include directive scanner: input register, scanner, result register.
// A source byte accepted into the input register moves through the scanner and, if it
// produces a result, that result waits in the result register until downstream takes it.
// Throughput: one byte per cycle; the input register takes a new transaction whenever it is
// empty or its held byte moves on, which needs the result register to be empty or emptied.
// Reset (rst_n low, asynchronous) empties both registers and returns the scanner to the
// start of a line with no keyword matched and no name open.
`timescale 1ns / 1ps
`default_nettype none

module include_directive_scanner
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] source_byte,
    input  wire logic       source_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_kind,
    output logic [7:0]      name_char,
    output logic            angle_form
);

    ids_pkg::item_t  item;
    ids_pkg::event_t ev;
    ids_pkg::event_t ev_reg;
    logic            ev_valid;
    logic            advance;
    logic            out_valid_reg;
    logic            out_valid_next;

    // The held byte moves through the scanner when the result register can take
    // whatever it produces. Bytes that produce no event still advance, so the
    // scanner state sees every transaction exactly once and in order.
    assign advance = item.valid && (!out_valid_reg || !out_stall);

    ids_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .source_end  (source_end),
        .advance     (advance),
        .item        (item)
    );

    ids_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // Result register: loaded on an advancing byte that produces an event, and
    // emptied when the downstream side takes the transaction.
    always_comb
    begin
        if (advance)
            out_valid_next = ev_valid;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The payload only changes when a new event is loaded, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (advance && ev_valid)
        begin
            ev_reg <= ev;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = ev_reg.kind;
    assign name_char  = ev_reg.ch;
    assign angle_form = ev_reg.angle;

endmodule : include_directive_scanner

`default_nettype wire

>>> rtl/ids_in_stage.sv
// Input register stage of the include directive scanner.
`timescale 1ns / 1ps
`default_nettype none

module ids_in_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    source_byte,
    input  wire logic          source_end,
    input  wire logic          advance,
    output ids_pkg::item_t     item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       eof_reg;
    logic       load;

    // The held item leaves when the scan stage takes it.
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= source_byte;
            eof_reg  <= source_end;
        end
    end

    assign item = '{valid: valid_reg, data: data_reg, eof: eof_reg};

endmodule : ids_in_stage

`default_nettype wire

>>> rtl/ids_scan.sv
// Scanner state registers and the per-byte next-state and event logic.
`timescale 1ns / 1ps
`default_nettype none

module ids_scan
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  ids_pkg::item_t     item,
    output logic               ev_valid,
    output ids_pkg::event_t    ev
);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [2:0] KW_LAST   = 3'd6;

    function automatic logic [7:0] keyword_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = 8'h69; // i
            3'd1:    r = 8'h6E; // n
            3'd2:    r = 8'h63; // c
            3'd3:    r = 8'h6C; // l
            3'd4:    r = 8'h75; // u
            3'd5:    r = 8'h64; // d
            3'd6:    r = 8'h65; // e
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    ids_pkg::phase_t phase_reg;
    ids_pkg::phase_t phase_next;
    logic [2:0]      kw_reg;
    logic [2:0]      kw_next;
    logic            bracket_reg;
    logic            bracket_next;
    logic            has_reg;
    logic            has_next;
    logic [7:0]      c;
    logic            line_end;
    logic            blank;

    assign c        = item.data;
    assign line_end = (c == CH_LF) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    assign blank    = (c == CH_SPACE) || (c == CH_TAB);

    always_comb
    begin
        phase_next   = phase_reg;
        kw_next      = kw_reg;
        bracket_next = bracket_reg;
        has_next     = has_reg;
        ev_valid     = 1'b0;
        ev           = '{kind: ids_pkg::EV_CHAR, ch: 8'h00, angle: bracket_reg};

        if (item.eof)
        begin
            if (phase_reg == ids_pkg::PH_NAME && has_reg)
            begin
                ev_valid = 1'b1;
                ev.kind  = ids_pkg::EV_DROP;
            end
            phase_next   = ids_pkg::PH_START;
            kw_next      = 3'd0;
            bracket_next = 1'b0;
            has_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                ids_pkg::PH_SLASH:
                begin
                    if (c == CH_SLASH)
                        phase_next = ids_pkg::PH_LCOMM;
                    else if (c == CH_STAR)
                        phase_next = ids_pkg::PH_BLOCK;
                    else if (line_end)
                        phase_next = ids_pkg::PH_START;
                    else
                        phase_next = ids_pkg::PH_INLINE;
                end
                ids_pkg::PH_ESCAPE:
                begin
                    phase_next = ids_pkg::PH_INLINE;
                end
                ids_pkg::PH_BLOCK:
                begin
                    if (c == CH_STAR)
                        phase_next = ids_pkg::PH_BSTAR;
                end
                ids_pkg::PH_BSTAR:
                begin
                    if (c == CH_SLASH)
                        phase_next = ids_pkg::PH_START;
                    else if (c != CH_STAR)
                        phase_next = ids_pkg::PH_BLOCK;
                end
                ids_pkg::PH_LCOMM:
                begin
                    if (line_end)
                        phase_next = ids_pkg::PH_START;
                end
                default:
                begin
                    if (line_end)
                    begin
                        if (phase_reg == ids_pkg::PH_NAME && has_reg)
                        begin
                            ev_valid = 1'b1;
                            ev.kind  = ids_pkg::EV_DROP;
                        end
                        phase_next = ids_pkg::PH_START;
                        kw_next    = 3'd0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            ids_pkg::PH_INLINE:
                            begin
                                if (c == CH_SLASH)
                                    phase_next = ids_pkg::PH_SLASH;
                                else if (c == CH_BSLASH)
                                    phase_next = ids_pkg::PH_ESCAPE;
                            end
                            ids_pkg::PH_HASH:
                            begin
                                if (blank)
                                begin
                                    if (kw_reg != 3'd0)
                                    begin
                                        phase_next = ids_pkg::PH_INLINE;
                                        kw_next    = 3'd0;
                                    end
                                end
                                else if (kw_reg <= KW_LAST && keyword_char(kw_reg) == c)
                                begin
                                    if (kw_reg == KW_LAST)
                                    begin
                                        phase_next = ids_pkg::PH_INCL;
                                        kw_next    = 3'd0;
                                    end
                                    else
                                    begin
                                        kw_next = kw_reg + 3'd1;
                                    end
                                end
                                else
                                begin
                                    phase_next = ids_pkg::PH_INLINE;
                                    kw_next    = 3'd0;
                                end
                            end
                            ids_pkg::PH_INCL:
                            begin
                                if (c == CH_LT || c == CH_QUOTE)
                                begin
                                    bracket_next = (c == CH_LT);
                                    has_next     = 1'b0;
                                    phase_next   = ids_pkg::PH_NAME;
                                end
                                else if (!blank)
                                begin
                                    phase_next = ids_pkg::PH_INLINE;
                                end
                            end
                            ids_pkg::PH_NAME:
                            begin
                                if (c == CH_LT)
                                begin
                                    if (has_reg)
                                    begin
                                        ev_valid = 1'b1;
                                        ev.kind  = ids_pkg::EV_DROP;
                                    end
                                    phase_next = ids_pkg::PH_INLINE;
                                end
                                else if ((c == CH_GT && bracket_reg)
                                         || (c == CH_QUOTE && !bracket_reg))
                                begin
                                    if (has_reg)
                                    begin
                                        ev_valid = 1'b1;
                                        ev.kind  = ids_pkg::EV_DONE;
                                    end
                                    phase_next = ids_pkg::PH_INLINE;
                                end
                                else
                                begin
                                    has_next = 1'b1;
                                    ev_valid = 1'b1;
                                    ev.kind  = ids_pkg::EV_CHAR;
                                    ev.ch    = c;
                                end
                            end
                            default:
                            begin
                                if (c == CH_HASH)
                                begin
                                    phase_next = ids_pkg::PH_HASH;
                                    kw_next    = 3'd0;
                                end
                                else if (c == CH_SLASH)
                                    phase_next = ids_pkg::PH_SLASH;
                                else if (blank)
                                    phase_next = ids_pkg::PH_START;
                                else
                                    phase_next = ids_pkg::PH_INLINE;
                            end
                        endcase
                    end
                end
            endcase

            // The name flag only means something while a name is open.
            if (phase_next != ids_pkg::PH_NAME)
                has_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ids_pkg::PH_START;
            kw_reg      <= 3'd0;
            bracket_reg <= 1'b0;
            has_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            kw_reg      <= kw_next;
            bracket_reg <= bracket_next;
            has_reg     <= has_next;
        end
    end

endmodule : ids_scan

`default_nettype wire
